// File: src/kaewm_pkg.sv
// Shared types and constants for the keyed adjusted moving-average block.
// No dependencies; imported by kaewm_div, the top level and the checker.
package kaewm_pkg;

    localparam int NUM_CODES = 256;
    localparam int ADDR_W    = (NUM_CODES > 1) ? $clog2(NUM_CODES) : 1;

    localparam int CODE_W  = 8;
    localparam int TS_W    = 63;
    localparam int SMP_W   = 32;
    localparam int SUM_W   = 64;
    localparam int WGT_W   = 33;
    localparam int MAG_W   = 48;
    localparam int Q_W     = 32;
    localparam int DECAY_W = 16;

    localparam int S_TDATA_W = 96;
    localparam int S_TUSER_W = 9;
    localparam int M_TDATA_W = 32;
    localparam int M_TUSER_W = 2;

    localparam int DIV_STEPS = 32;

    localparam logic [DECAY_W-1:0] DECAY_RESET = 16'h8000;
    localparam logic [WGT_W-1:0]   ONE_Q16     = 33'h0_0001_0000;
    localparam logic [Q_W-1:0]     MEAN_MAX    = 32'h7FFF_FFFF;
    localparam logic [Q_W-1:0]     MEAN_MIN    = 32'h8000_0000;

    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [WGT_W-1:0] weight;
        logic [TS_W-1:0]  last_time;
        logic             has_avg;
    } entry_t;

    typedef struct packed {
        logic done;
        logic ovf;
    } div_status_t;

endpackage

// File: src/kaewm_ram.sv
// Generic single-write, single-read memory with registered read data.
// No dependencies.
module kaewm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                              clk,
    input  logic                              wr_en,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                  wr_data,
    input  logic                              rd_en,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
    output logic [WIDTH-1:0]                  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: src/kaewm_div.sv
// Iterative restoring divider: (mag * 2^16) / divisor, one quotient bit a cycle.
// One subtractor does the overflow check and every step. Depends on kaewm_pkg.
module kaewm_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [kaewm_pkg::MAG_W-1:0]  mag,
    input  logic [kaewm_pkg::WGT_W-1:0]  divisor,
    output logic [kaewm_pkg::Q_W-1:0]    quot,
    output kaewm_pkg::div_status_t       status
);
    import kaewm_pkg::*;

    localparam int CNT_W = $clog2(DIV_STEPS);

    logic             busy_reg, busy_next;
    logic             chk_reg, chk_next;
    logic             done_reg, done_next;
    logic             ovf_reg, ovf_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [WGT_W-1:0] rem_reg, rem_next;
    logic [Q_W-1:0]   shq_reg, shq_next;
    logic [WGT_W-1:0] dvs_reg, dvs_next;

    logic [WGT_W:0]   sub_a;
    logic [WGT_W+1:0] diff;
    logic             borrow;

    always_comb
    begin
        sub_a  = chk_reg ? {1'b0, rem_reg} : {rem_reg, shq_reg[Q_W-1]};
        diff   = {1'b0, sub_a} - {2'b00, dvs_reg};
        borrow = diff[WGT_W+1];
    end

    always_comb
    begin
        busy_next = busy_reg;
        chk_next  = chk_reg;
        done_next = 1'b0;
        ovf_next  = ovf_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        shq_next  = shq_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            chk_next  = 1'b1;
            ovf_next  = 1'b0;
            cnt_next  = '0;
            rem_next  = {1'b0, mag[MAG_W-1:16]};
            shq_next  = {mag[15:0], 16'h0000};
            dvs_next  = divisor;
        end
        else if (busy_reg && chk_reg)
        begin
            chk_next = 1'b0;
            if (!borrow)
            begin
                ovf_next  = 1'b1;
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            if (!borrow)
            begin
                rem_next = diff[WGT_W-1:0];
            end
            else
            begin
                rem_next = sub_a[WGT_W-1:0];
            end
            shq_next = {shq_reg[Q_W-2:0], ~borrow};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            chk_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            chk_reg  <= chk_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ovf_reg <= ovf_next;
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        shq_reg <= shq_next;
        dvs_reg <= dvs_next;
    end

    assign quot        = shq_reg;
    assign status.done = done_reg;
    assign status.ovf  = ovf_reg;

endmodule

// File: src/keyed_adjusted_ewm_top.sv
// Top level of the keyed adjusted moving average: sequencer, shared multiplier,
// state memory and output register. Depends on kaewm_pkg, kaewm_ram, kaewm_div.
//
// Usage:
//   Slave channel (s_*) carries one request per update: timestamp and sample in
//   s_tdata, stream code and missing flag in s_tuser. Master channel (m_*)
//   returns exactly one result per request: mean in m_tdata, mean_missing and
//   order_error in m_tuser.
//   The decay register is written through cfg_wr_en / cfg_wr_data; the user must do so
//   only while idle, as the block itself does not enforce this.
//   A present sample of a stream that already has an average goes through sequencing,
//   6 multiply/accumulate steps on one 26x17 multiplier, 1 overflow check and 32
//   divider steps, and finishing; the first present sample of a stream skips the
//   multiply steps; a missing sample, a backwards timestamp or an unknown code goes
//   from the check straight to the result.
//   The divider loop sets the rate. s_tready is high only while idle.
//   A finished result waits in the output register while the receiver stalls;
//   the block accepts the next request meanwhile and holds its own result until
//   the register is free.
//   Reset clears the decay to 0.5, all per-stream flags and the output valid;
//   no clearing pass is needed.
module keyed_adjusted_ewm_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [kaewm_pkg::S_TDATA_W-1:0]  s_tdata,  // timestamp[62:0], sample[94:63], zero
    input  logic [kaewm_pkg::S_TUSER_W-1:0]  s_tuser,  // stream_code[7:0], sample_missing[8]
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [kaewm_pkg::M_TDATA_W-1:0]  m_tdata,  // mean[31:0]
    output logic [kaewm_pkg::M_TUSER_W-1:0]  m_tuser,  // mean_missing[0], order_error[1]
    input  logic                             cfg_wr_en,
    input  logic [kaewm_pkg::DECAY_W-1:0]    cfg_wr_data
);
    import kaewm_pkg::*;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_CHECK = 4'd1;
    localparam logic [3:0] ST_M0    = 4'd2;
    localparam logic [3:0] ST_M1    = 4'd3;
    localparam logic [3:0] ST_M2    = 4'd4;
    localparam logic [3:0] ST_M3    = 4'd5;
    localparam logic [3:0] ST_M4    = 4'd6;
    localparam logic [3:0] ST_M5    = 4'd7;
    localparam logic [3:0] ST_DIVGO = 4'd8;
    localparam logic [3:0] ST_DIVWT = 4'd9;
    localparam logic [3:0] ST_DONE  = 4'd10;

    logic [3:0]           state_reg, state_next;
    logic [DECAY_W-1:0]   decay_reg, decay_next;
    logic [NUM_CODES-1:0] has_time_reg, has_time_next;

    logic [CODE_W-1:0]    code_reg, code_next;
    logic [TS_W-1:0]      ts_reg, ts_next;
    logic [SMP_W-1:0]     smp_reg, smp_next;
    logic                 miss_reg, miss_next;

    logic [SUM_W-1:0]     sum_reg, sum_next;
    logic [WGT_W-1:0]     w_reg, w_next;
    logic signed [65:0]   acc_reg, acc_next;
    logic signed [42:0]   prod_reg, prod_next;

    logic [Q_W-1:0]       res_mean_reg, res_mean_next;
    logic                 res_miss_reg, res_miss_next;
    logic                 res_err_reg, res_err_next;

    logic                 out_valid_reg, out_valid_next;
    logic [Q_W-1:0]       out_mean_reg, out_mean_next;
    logic                 out_miss_reg, out_miss_next;
    logic                 out_err_reg, out_err_next;

    logic                 s_accept;
    logic                 out_free;
    logic [ADDR_W-1:0]    addr;
    logic                 in_range;
    logic                 order_bad;
    logic                 avg_known;
    entry_t               rd_entry;
    entry_t               wr_entry;
    logic                 ram_we;
    logic [$bits(entry_t)-1:0] ram_rdata;

    logic signed [25:0]   mul_a;
    logic signed [16:0]   mul_b;
    logic signed [65:0]   prod_ext;
    logic [SUM_W-1:0]     sum_abs;
    logic                 div_start;
    logic [Q_W-1:0]       div_quot;
    div_status_t          div_stat;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign addr     = ADDR_W'(code_reg);
    assign in_range = 32'(code_reg) < NUM_CODES;
    assign rd_entry = entry_t'(ram_rdata);
    assign order_bad = in_range && has_time_reg[addr] && (ts_reg < rd_entry.last_time);
    assign avg_known = has_time_reg[addr] && rd_entry.has_avg;

    assign mul_b    = signed'({1'b0, decay_reg});
    assign prod_ext = {{23{prod_reg[42]}}, prod_reg};
    assign sum_abs  = sum_reg[SUM_W-1] ? (~sum_reg + 64'd1) : sum_reg;
    assign div_start = (state_reg == ST_DIVGO);

    always_comb
    begin
        unique case (state_reg)
            ST_M0:   mul_a = signed'({2'b00, sum_reg[23:0]});
            ST_M1:   mul_a = signed'({sum_reg[48], sum_reg[48:24]});
            ST_M2:   mul_a = signed'({2'b00, w_reg[23:0]});
            ST_M3:   mul_a = signed'({17'h0_0000, w_reg[32:24]});
            default: mul_a = '0;
        endcase
    end

    always_comb
    begin
        ram_we   = 1'b0;
        wr_entry = rd_entry;
        if (state_reg == ST_CHECK && in_range && !order_bad && miss_reg)
        begin
            ram_we             = 1'b1;
            wr_entry.last_time = ts_reg;
            wr_entry.has_avg   = avg_known;
        end
        else if (state_reg == ST_DIVGO)
        begin
            ram_we             = 1'b1;
            wr_entry.sum       = sum_reg;
            wr_entry.weight    = w_reg;
            wr_entry.last_time = ts_reg;
            wr_entry.has_avg   = 1'b1;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        decay_next     = cfg_wr_en ? cfg_wr_data : decay_reg;
        has_time_next  = has_time_reg;
        code_next      = code_reg;
        ts_next        = ts_reg;
        smp_next       = smp_reg;
        miss_next      = miss_reg;
        sum_next       = sum_reg;
        w_next         = w_reg;
        acc_next       = acc_reg;
        prod_next      = prod_reg;
        res_mean_next  = res_mean_reg;
        res_miss_next  = res_miss_reg;
        res_err_next   = res_err_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_mean_next  = out_mean_reg;
        out_miss_next  = out_miss_reg;
        out_err_next   = out_err_reg;

        if (ram_we)
        begin
            has_time_next[addr] = 1'b1;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    code_next  = s_tuser[CODE_W-1:0];
                    miss_next  = s_tuser[CODE_W];
                    ts_next    = s_tdata[TS_W-1:0];
                    smp_next   = s_tdata[TS_W+SMP_W-1:TS_W];
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                res_mean_next = '0;
                res_miss_next = 1'b1;
                res_err_next  = 1'b0;
                if (order_bad)
                begin
                    res_err_next = 1'b1;
                    state_next   = ST_DONE;
                end
                else if (!in_range || miss_reg)
                begin
                    state_next = ST_DONE;
                end
                else if (!avg_known)
                begin
                    sum_next   = {{(SUM_W-SMP_W){smp_reg[SMP_W-1]}}, smp_reg};
                    w_next     = ONE_Q16;
                    state_next = ST_DIVGO;
                end
                else
                begin
                    sum_next   = rd_entry.sum;
                    w_next     = rd_entry.weight;
                    state_next = ST_M0;
                end
            end
            ST_M0:
            begin
                prod_next  = mul_a * mul_b;
                state_next = ST_M1;
            end
            ST_M1:
            begin
                acc_next   = prod_ext;
                prod_next  = mul_a * mul_b;
                state_next = ST_M2;
            end
            ST_M2:
            begin
                acc_next   = acc_reg + (prod_ext <<< 24);
                prod_next  = mul_a * mul_b;
                state_next = ST_M3;
            end
            ST_M3:
            begin
                sum_next   = {{14{acc_reg[65]}}, acc_reg[65:16]}
                           + {{(SUM_W-SMP_W){smp_reg[SMP_W-1]}}, smp_reg};
                acc_next   = prod_ext;
                prod_next  = mul_a * mul_b;
                state_next = ST_M4;
            end
            ST_M4:
            begin
                acc_next   = acc_reg + (prod_ext <<< 24);
                state_next = ST_M5;
            end
            ST_M5:
            begin
                w_next     = acc_reg[48:16] + ONE_Q16;
                state_next = ST_DIVGO;
            end
            ST_DIVGO:
            begin
                state_next = ST_DIVWT;
            end
            ST_DIVWT:
            begin
                if (div_stat.done)
                begin
                    res_miss_next = 1'b0;
                    res_err_next  = 1'b0;
                    if (sum_reg[SUM_W-1])
                    begin
                        if (div_stat.ovf || div_quot > MEAN_MIN)
                        begin
                            res_mean_next = MEAN_MIN;
                        end
                        else
                        begin
                            res_mean_next = ~div_quot + 32'd1;
                        end
                    end
                    else
                    begin
                        if (div_stat.ovf || div_quot[Q_W-1])
                        begin
                            res_mean_next = MEAN_MAX;
                        end
                        else
                        begin
                            res_mean_next = div_quot;
                        end
                    end
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_mean_next  = res_mean_reg;
                    out_miss_next  = res_miss_reg;
                    out_err_next   = res_err_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            decay_reg     <= DECAY_RESET;
            has_time_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            decay_reg     <= decay_next;
            has_time_reg  <= has_time_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        code_reg     <= code_next;
        ts_reg       <= ts_next;
        smp_reg      <= smp_next;
        miss_reg     <= miss_next;
        sum_reg      <= sum_next;
        w_reg        <= w_next;
        acc_reg      <= acc_next;
        prod_reg     <= prod_next;
        res_mean_reg <= res_mean_next;
        res_miss_reg <= res_miss_next;
        res_err_reg  <= res_err_next;
        out_mean_reg <= out_mean_next;
        out_miss_reg <= out_miss_next;
        out_err_reg  <= out_err_next;
    end

    kaewm_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (NUM_CODES)
    ) u_state_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (addr),
        .wr_data (wr_entry),
        .rd_en   (s_accept),
        .rd_addr (ADDR_W'(s_tuser[CODE_W-1:0])),
        .rd_data (ram_rdata)
    );

    kaewm_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .mag     (sum_abs[MAG_W-1:0]),
        .divisor (w_reg),
        .quot    (div_quot),
        .status  (div_stat)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_mean_reg;
    assign m_tuser  = {out_err_reg, out_miss_reg};

endmodule

// File: src/kaewm_checker.sv
// Port-level checks for the keyed adjusted moving-average top level.
// Depends on kaewm_pkg; bound to keyed_adjusted_ewm_top below.
module kaewm_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic [kaewm_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic [kaewm_pkg::S_TUSER_W-1:0]  s_tuser,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [kaewm_pkg::M_TDATA_W-1:0]  m_tdata,
    input  logic [kaewm_pkg::M_TUSER_W-1:0]  m_tuser
);
    import kaewm_pkg::*;

    logic s_req;
    assign s_req = s_tvalid && s_tready && (s_tdata[S_TDATA_W-1] || !s_tdata[S_TDATA_W-1])
                 && (s_tuser[0] || !s_tuser[0]);

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_req |=> !s_tready)
        else $error("ready stayed high after a request was taken");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_error_is_missing: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1] |-> m_tuser[0])
        else $error("order error without missing mean");

    a_missing_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata == '0)
        else $error("missing mean carries a non-zero value");

endmodule

bind keyed_adjusted_ewm_top kaewm_checker u_checker (.*);
